@@ rtl/led_panel_bitplane_generator_assert.svh @@
// ----------------------------------------------------------------------------
// led_panel_bitplane_generator_assert.svh
// Assertion macros for the bit-plane generator, clocked on clk, reset rst_n
// ----------------------------------------------------------------------------
`ifndef LED_PANEL_BITPLANE_GENERATOR_ASSERT_SVH
`define LED_PANEL_BITPLANE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define LPBG_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define LPBG_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/lpbg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpbg_pkg
// Types, constants and gamma helpers shared by the bit-plane generator
// ----------------------------------------------------------------------------
package lpbg_pkg;

    localparam int ADDR_W      = 14;
    localparam int PLANE_W     = 3;
    localparam int BITS_W      = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PLANE_W-1:0] PLANE_LAST = 3'd7;

    // rgb565 field masks
    localparam logic [15:0] RED_MASK   = 16'hf800;
    localparam logic [15:0] GREEN_MASK = 16'h07e0;
    localparam logic [15:0] BLUE_MASK  = 16'h001f;

    // position of each channel within a 3-bit triplet
    localparam logic [2:0] TRIPLET_R = 3'b001;
    localparam logic [2:0] TRIPLET_G = 3'b010;
    localparam logic [2:0] TRIPLET_B = 3'b100;

    typedef struct packed {
        logic [15:0] top_pixel;
        logic [15:0] bottom_pixel;
        logic [4:0]  row_select;
        logic [5:0]  column;
    } pixel_pair_t;

    typedef struct packed {
        logic [PLANE_W-1:0] plane_index;
        logic [ADDR_W-1:0]  plane_address;
        logic [BITS_W-1:0]  plane_bits;
        logic               last_plane;
    } plane_beat_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb8_t;

    // one queue entry: corrected pixels and plane-0 address
    typedef struct packed {
        rgb8_t             top;
        rgb8_t             bottom;
        logic [ADDR_W-1:0] base_addr;
    } work_t;

    typedef struct packed {
        logic               busy;
        logic [PLANE_W-1:0] plane;
    } back_status_t;

    // square each channel into 8 bits
    function automatic rgb8_t gamma_expand(logic [15:0] pix);
        logic [4:0]  r5;
        logic [5:0]  g6;
        logic [4:0]  b5;
        logic [9:0]  r_sq;
        logic [11:0] g_sq;
        logic [9:0]  b_sq;
        rgb8_t       c;
        r5   = 5'((pix & RED_MASK) >> 11);
        g6   = 6'((pix & GREEN_MASK) >> 5);
        b5   = 5'(pix & BLUE_MASK);
        r_sq = 10'(r5) * 10'(r5);
        g_sq = 12'(g6) * 12'(g6);
        b_sq = 10'(b5) * 10'(b5);
        c.r  = r_sq[9:2];
        c.g  = g_sq[11:4];
        c.b  = b_sq[9:2];
        return c;
    endfunction

    // bit p of each channel packed as r, g, b from bit 0
    function automatic logic [2:0] plane_triplet(rgb8_t c, logic [PLANE_W-1:0] p);
        logic [2:0] t;
        t = 3'b000;
        if (c.r[p])
        begin
            t = t | TRIPLET_R;
        end
        if (c.g[p])
        begin
            t = t | TRIPLET_G;
        end
        if (c.b[p])
        begin
            t = t | TRIPLET_B;
        end
        return t;
    endfunction

endpackage

@@ rtl/lpbg_front.sv @@
// ----------------------------------------------------------------------------
// lpbg_front
// Input stage: takes a pixel pair, gamma corrects it and forms the base address
// ----------------------------------------------------------------------------
module lpbg_front import lpbg_pkg::*; #(
    parameter int PANEL_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  pixel_pair_t pixel_pair,
    output logic        work_valid,
    input  logic        work_ready,
    output work_t       work
);

    localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(PANEL_WIDTH);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    work_t stage_reg;
    work_t stage_next;
    logic  accept;

    // stage frees up when its entry moves into the queue
    assign full       = stage_valid_reg && !work_ready;
    assign accept     = push && !full;
    assign work_valid = stage_valid_reg;
    assign work       = stage_reg;

    // classify the beat: corrected colors and plane-0 address
    always_comb
    begin
        stage_next.top       = gamma_expand(pixel_pair.top_pixel);
        stage_next.bottom    = gamma_expand(pixel_pair.bottom_pixel);
        stage_next.base_addr = ADDR_W'(pixel_pair.row_select) * ROW_STEP
                             + ADDR_W'(pixel_pair.column);
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (work_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    // stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

@@ rtl/lpbg_queue.sv @@
// ----------------------------------------------------------------------------
// lpbg_queue
// Short work queue decoupling the front stage from the plane sequencer
// ----------------------------------------------------------------------------
module lpbg_queue import lpbg_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  work_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output work_t rd_data
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = count_reg != COUNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/lpbg_back.sv @@
// ----------------------------------------------------------------------------
// lpbg_back
// Plane sequencer: walks planes 0 to 7 of one entry into an output register
// ----------------------------------------------------------------------------
module lpbg_back import lpbg_pkg::*; #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         work_valid,
    output logic         work_ready,
    input  work_t        work,
    output logic         empty,
    input  logic         pop,
    output plane_beat_t  plane_beat,
    output back_status_t status
);

    localparam int                PLANE_SIZE = PANEL_WIDTH * PANEL_HEIGHT / 2;
    localparam logic [ADDR_W-1:0] PLANE_STEP = ADDR_W'(PLANE_SIZE);

    logic               busy_reg;
    logic               busy_next;
    logic [PLANE_W-1:0] plane_reg;
    logic [PLANE_W-1:0] plane_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    work_t              cur_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    plane_beat_t        out_reg;
    plane_beat_t        beat;
    logic               advance;
    logic               emit;
    logic               done;
    logic               load;

    // output register takes a new beat when empty or being popped
    assign advance    = !out_valid_reg || pop;
    assign emit       = busy_reg && advance;
    assign done       = emit && (plane_reg == PLANE_LAST);
    assign work_ready = !busy_reg || done;
    assign load       = work_valid && work_ready;

    assign empty       = !out_valid_reg;
    assign plane_beat  = out_reg;
    assign status.busy  = busy_reg;
    assign status.plane = plane_reg;

    // current plane beat
    always_comb
    begin
        beat.plane_index   = plane_reg;
        beat.plane_address = addr_reg;
        beat.plane_bits    = {plane_triplet(cur_reg.bottom, plane_reg),
                              plane_triplet(cur_reg.top, plane_reg)};
        beat.last_plane    = plane_reg == PLANE_LAST;
    end

    // sequencer next state
    always_comb
    begin
        busy_next      = busy_reg;
        plane_next     = plane_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            plane_next     = plane_reg + PLANE_W'(1);
            addr_next      = addr_reg + PLANE_STEP;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            busy_next  = 1'b1;
            plane_next = '0;
            addr_next  = work.base_addr;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            plane_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            plane_reg     <= plane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (load)
        begin
            cur_reg <= work;
        end
        if (emit)
        begin
            out_reg <= beat;
        end
    end

endmodule

@@ rtl/led_panel_bitplane_generator.sv @@
// ----------------------------------------------------------------------------
// led_panel_bitplane_generator
// Gamma corrects an rgb565 pixel pair and emits its eight bit-plane beats
// ----------------------------------------------------------------------------
//  channel     | handshake         | payload
//  ------------+-------------------+------------------------------
//  pixel in    | push / full       | pixel_pair (pixel_pair_t)
//  plane out   | pop / empty       | plane_beat (plane_beat_t)
//
//  the back end's 3-bit plane counter sends one plane beat per cycle while
//  pop keeps the output register free, and pairs stream back to back.
//  after the accepting edge, the first beat still passes the queue, the
//  sequencer load and the output register before it shows up.
//  reset clears the valid and busy flags, queue pointers and count, and the
//  plane counter only.
//  a stall on pop holds the output register; the queue and front stage keep
//  taking pixel pairs until both fill, then full rises.
// ----------------------------------------------------------------------------
`include "led_panel_bitplane_generator_assert.svh"

module led_panel_bitplane_generator import lpbg_pkg::*; #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  pixel_pair_t pixel_pair,
    output logic        empty,
    input  logic        pop,
    output plane_beat_t plane_beat
);

    logic         front_valid;
    logic         front_ready;
    work_t        front_work;
    logic         queue_valid;
    logic         queue_ready;
    work_t        queue_work;
    back_status_t back_status;

    // gamma and address front end
    lpbg_front #(
        .PANEL_WIDTH (PANEL_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_pair (pixel_pair),
        .work_valid (front_valid),
        .work_ready (front_ready),
        .work       (front_work)
    );

    // decoupling queue
    lpbg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_work),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_data  (queue_work)
    );

    // plane sequencer
    lpbg_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_valid (queue_valid),
        .work_ready (queue_ready),
        .work       (queue_work),
        .empty      (empty),
        .pop        (pop),
        .plane_beat (plane_beat),
        .status     (back_status)
    );

    // a pending non-last beat means the sequencer still owns that pair
    `LPBG_ASSERT_IMPL(a_busy_mid_pair, (!empty && !plane_beat.last_plane),
        back_status.busy, "plane beat pending with idle sequencer")

    // popping a non-last beat brings the next plane on the following cycle
    `LPBG_ASSERT_NEXT(a_next_plane, (pop && !empty && !plane_beat.last_plane),
        (!empty && (plane_beat.plane_index == $past(plane_beat.plane_index) + PLANE_W'(1))),
        "plane sequence broken after pop")

    // the sequencer counter runs one plane ahead of the beat waiting in the output register
    `LPBG_ASSERT_IMPL(a_plane_track, (!empty && back_status.busy && !plane_beat.last_plane),
        (back_status.plane == plane_beat.plane_index + PLANE_W'(1)),
        "plane counter out of step with output beat")

endmodule

@@ test/plane_beat_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plane_beat_checker
// Watches the pixel-pair and plane-beat queues of the bit-plane generator,
// works out the eight plane beats of every accepted pixel pair and compares
// each popped beat, field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module plane_beat_checker import lpbg_pkg::*; #(
    parameter int PANEL_WIDTH  = 64,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  pixel_pair_t pixel_pair,
    input  logic        empty,
    input  logic        pop,
    input  plane_beat_t plane_beat,
    output int          fail_count,
    output int          beats_pending
);

    localparam int PLANE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 2;
    localparam int PLANE_COUNT = 8;

    plane_beat_t owed_beats[$];
    int          mismatches;
    int          beats_seen;

    assign fail_count = mismatches;

    // one line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("checker: beat %0d %s got 0x%0h want 0x%0h", beats_seen, what, got, want);
        mismatches++;
    endtask

    // rgb565 to rgb888 by squaring each channel
    function automatic rgb8_t square_channels(input logic [15:0] pix);
        logic [9:0]  red_sq;
        logic [11:0] green_sq;
        logic [9:0]  blue_sq;
        rgb8_t       levels;
        red_sq   = {5'd0, pix[15:11]} * {5'd0, pix[15:11]};
        green_sq = {6'd0, pix[10:5]} * {6'd0, pix[10:5]};
        blue_sq  = {5'd0, pix[4:0]} * {5'd0, pix[4:0]};
        levels.r = red_sq[9:2];
        levels.g = green_sq[11:4];
        levels.b = blue_sq[9:2];
        return levels;
    endfunction

    // queue the eight plane beats of one pixel pair, plane 0 first
    task automatic predict_planes(input pixel_pair_t pair);
        rgb8_t       upper;
        rgb8_t       lower;
        plane_beat_t beat;
        int          full_addr;
        upper = square_channels(pair.top_pixel);
        lower = square_channels(pair.bottom_pixel);
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            full_addr          = p * PLANE_BYTES + int'(pair.row_select) * PANEL_WIDTH
                                 + int'(pair.column);
            beat.plane_index   = PLANE_W'(p);
            beat.plane_address = ADDR_W'(full_addr);
            beat.plane_bits    = {lower.b[p], lower.g[p], lower.r[p],
                                  upper.b[p], upper.g[p], upper.r[p]};
            beat.last_plane    = (PLANE_W'(p) == PLANE_LAST);
            owed_beats.push_back(beat);
        end
    endtask

    // sample both queues at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        plane_beat_t want;
        if (!rst_n)
        begin
            owed_beats.delete();
            mismatches = 0;
            beats_seen <= 0;
        end
        else
        begin
            // accepted pixel pair
            if (push && !full)
            begin
                predict_planes(pixel_pair);
            end

            // accepted plane beat
            if (pop && !empty)
            begin
                if (owed_beats.size() == 0)
                begin
                    report_mismatch("with nothing owed, plane", plane_beat.plane_index, 0);
                end
                else
                begin
                    want = owed_beats.pop_front();
                    if (plane_beat.plane_index !== want.plane_index)
                    begin
                        report_mismatch("plane_index", plane_beat.plane_index,
                                        want.plane_index);
                    end
                    if (plane_beat.plane_address !== want.plane_address)
                    begin
                        report_mismatch("plane_address", plane_beat.plane_address,
                                        want.plane_address);
                    end
                    if (plane_beat.plane_bits !== want.plane_bits)
                    begin
                        report_mismatch("plane_bits", plane_beat.plane_bits,
                                        want.plane_bits);
                    end
                    if (plane_beat.last_plane !== want.last_plane)
                    begin
                        report_mismatch("last_plane", plane_beat.last_plane,
                                        want.last_plane);
                    end
                end
                beats_seen <= beats_seen + 1;
            end
        end
        beats_pending = owed_beats.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives pixel pairs into the bit-plane generator, directed corners first and
// then random pairs, under three idling mixes on the push and pop sides; the
// checker beside the block predicts and compares every plane beat.
// ----------------------------------------------------------------------------
module tb import lpbg_pkg::*;;

    localparam int RANDOM_PER_PHASE = 38;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 16;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        push       = 1'b0;
    logic        pop        = 1'b0;
    pixel_pair_t pixel_pair = '0;
    logic        full;
    logic        empty;
    plane_beat_t plane_beat;

    int          fail_count;
    int          beats_pending;
    int          send_idle_pct = 8;
    int          recv_idle_pct = 88;
    int          cycle_count   = 0;

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    led_panel_bitplane_generator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_pair (pixel_pair),
        .empty      (empty),
        .pop        (pop),
        .plane_beat (plane_beat)
    );

    plane_beat_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .pixel_pair    (pixel_pair),
        .empty         (empty),
        .pop           (pop),
        .plane_beat    (plane_beat),
        .fail_count    (fail_count),
        .beats_pending (beats_pending)
    );

    // pop side stalls at random
    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // run-length guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // offer one pixel pair, hold it until the block takes it
    task automatic send_pair(input logic [15:0] upper, input logic [15:0] lower,
                             input logic [4:0] row, input logic [5:0] col);
        pixel_pair_t pair;
        pair.top_pixel    = upper;
        pair.bottom_pixel = lower;
        pair.row_select   = row;
        pair.column       = col;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        pixel_pair <= pair;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // random pair, row and column pinned to an edge now and then
    task automatic send_random_pair();
        logic [4:0] row;
        logic [5:0] col;
        row = 5'($urandom_range(31));
        col = 6'($urandom_range(63));
        case ($urandom_range(7))
            0: row = 5'd0;
            1: row = 5'd31;
            2: col = 6'd0;
            3: col = 6'd63;
            default: ;
        endcase
        send_pair(16'($urandom), 16'($urandom), row, col);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners: blank, full white, each channel alone, patterns
        send_pair(16'h0000, 16'h0000, 5'd0,  6'd0);
        send_pair(16'hffff, 16'hffff, 5'd31, 6'd63);
        send_pair(16'hf800, 16'h0000, 5'd0,  6'd63);
        send_pair(16'h07e0, 16'h0000, 5'd31, 6'd0);
        send_pair(16'h001f, 16'h0000, 5'd5,  6'd9);
        send_pair(16'h0000, 16'hf800, 5'd17, 6'd33);
        send_pair(16'h0000, 16'h07e0, 5'd8,  6'd1);
        send_pair(16'h0000, 16'h001f, 5'd1,  6'd62);
        send_pair(16'haaaa, 16'h5555, 5'd21, 6'd42);
        send_pair(16'h5555, 16'haaaa, 5'd10, 6'd21);
        send_pair(16'h0821, 16'h0821, 5'd30, 6'd31);
        send_pair(16'h7bef, 16'h8410, 5'd15, 6'd32);
        send_pair(16'h8410, 16'h7bef, 5'd16, 6'd31);
        send_pair(16'hffff, 16'h0000, 5'd31, 6'd0);
        send_pair(16'h0000, 16'hffff, 5'd0,  6'd63);
        send_pair(16'hf81f, 16'h07e0, 5'd31, 6'd63);

        // push side busy, pop side calm
        repeat (RANDOM_PER_PHASE) send_random_pair();

        // push side calm, pop side busy
        send_idle_pct = 88;
        recv_idle_pct = 8;
        repeat (RANDOM_PER_PHASE) send_random_pair();

        // no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_pair();
        push <= 1'b0;

        // drain
        while (beats_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && beats_pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
